[hdl/wbps_pkg.sv]
// shared types and constants of the wildcard byte pattern scanner
`default_nettype none

package wbps_pkg;

    localparam logic [7:0] WILDCARD_BYTE = 8'hFF;
    localparam int STORE_SPAN = 256;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SCAN  = 1'b1
    } t_op;

    typedef struct packed {
        logic       func;
        logic [7:0] pattern_index;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic       idx_ok;
        logic [7:0] pattern_index;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_cmd;

endpackage

`default_nettype wire

[hdl/wbps_front.sv]
// front end: accepts items, decodes them into commands and queues them
`default_nettype none

module wbps_front #(
    parameter int MAX_PATTERN = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wbps_pkg::t_in_item   i_in_item,
    output logic                 o_cmd_valid,
    output wbps_pkg::t_cmd       o_cmd,
    input  wire                  i_pop
);

    wbps_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           push;
    logic           pop;
    wbps_pkg::t_cmd cmd_in;

    always_comb begin
        cmd_in.op            = (i_in_item.func == 1'b1) ? wbps_pkg::OP_SCAN
                                                        : wbps_pkg::OP_WRITE;
        cmd_in.idx_ok        = ({24'd0, i_in_item.pattern_index} < 32'(MAX_PATTERN));
        cmd_in.pattern_index = i_in_item.pattern_index;
        cmd_in.data_byte     = i_in_item.data_byte;
        cmd_in.first_byte    = i_in_item.first_byte;
        cmd_in.last_byte     = i_in_item.last_byte;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[hdl/wbps_back.sv]
// back end: pattern store, parallel partial match flags and result register
`default_nettype none

module wbps_back #(
    parameter int MAX_PATTERN = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_valid,
    input  wbps_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    input  wire  [7:0]           i_len,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output wbps_pkg::t_out_item  o_out_item
);

    localparam int LEN_CAP = (MAX_PATTERN < wbps_pkg::STORE_SPAN) ? MAX_PATTERN
                                                                  : wbps_pkg::STORE_SPAN - 1;

    logic [7:0]             r_store [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_flags;
    logic [MAX_PATTERN-1:0] n_flags;
    logic [31:0]            r_count;
    logic [31:0]            n_count;
    logic                   r_rep;
    logic                   n_rep;
    logic                   r_out_valid;
    wbps_pkg::t_out_item    r_out;

    logic                   go;
    logic                   scan;
    logic                   wr;
    logic [7:0]             len_eff;
    logic [MAX_PATTERN-1:0] flags_in;
    logic [MAX_PATTERN-1:0] adv;
    logic [MAX_PATTERN-1:0] hit_sel;
    logic [MAX_PATTERN-1:0] pos_match;
    logic [31:0]            count_in;
    logic                   rep_in;
    logic                   hit;
    logic                   res_valid;
    wbps_pkg::t_out_item    res;

    assign go    = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = go;
    assign scan  = go && (i_cmd.op == wbps_pkg::OP_SCAN);
    assign wr    = go && (i_cmd.op == wbps_pkg::OP_WRITE) && i_cmd.idx_ok;

    assign len_eff = ({24'd0, i_len} > 32'(LEN_CAP)) ? 8'(LEN_CAP) : i_len;

    always_comb begin
        flags_in = i_cmd.first_byte ? '0 : r_flags;
        count_in = i_cmd.first_byte ? 32'd0 : r_count;
        rep_in   = i_cmd.first_byte ? 1'b0 : r_rep;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pos_match[j] = (r_store[j] == wbps_pkg::WILDCARD_BYTE) ||
                           (r_store[j] == i_cmd.data_byte);
            hit_sel[j]   = ((32'(j) + 32'd1) == {24'd0, len_eff});
        end
        adv[0] = (len_eff != 8'd0) && pos_match[0];
        for (int j = 1; j < MAX_PATTERN; j++) begin
            adv[j] = (32'(j) < {24'd0, len_eff}) && flags_in[j-1] && pos_match[j];
        end
        hit       = !rep_in && (len_eff != 8'd0) && (|(adv & hit_sel));
        res_valid = hit || (i_cmd.last_byte && !rep_in);
        res.found        = hit;
        res.match_offset = hit ? (count_in - {24'd0, len_eff - 8'd1}) : 32'd0;

        if (i_cmd.last_byte) begin
            n_flags = '0;
            n_count = 32'd0;
            n_rep   = 1'b0;
        end else begin
            n_flags = adv;
            n_count = count_in + 32'd1;
            n_rep   = rep_in || hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_count     <= 32'd0;
            r_rep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (scan) begin
                r_flags <= n_flags;
                r_count <= n_count;
                r_rep   <= n_rep;
            end
            if (scan && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan && res_valid) begin
            r_out <= res;
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (wr && ({24'd0, i_cmd.pattern_index} == 32'(j))) begin
                r_store[j] <= i_cmd.data_byte;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan && i_cmd.last_byte) |=> (r_count == 32'd0 && !r_rep && r_flags == '0))
        else $error("region state not cleared after last byte");

    a_hit_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan && hit && !i_cmd.last_byte) |=> r_rep)
        else $error("match not recorded as reported");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.match_offset == 32'd0))
        else $error("not found result with nonzero offset");

    a_result_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan && res_valid) |=> r_out_valid)
        else $error("result lost");

endmodule

`default_nettype wire

[hdl/wildcard_byte_pattern_scanner.sv]
// top level of the wildcard byte pattern scanner
`default_nettype none

// Streams pattern writes and region bytes at one item per cycle sustained
// while the output is not stalled. An accepted item waits in a two-entry
// queue until the back end executes it; its result is then registered in the
// output register. The rate is set by the partial match flag vector, which
// advances by one byte per cycle with every pattern position compared in
// parallel against its own store entry. Each region gives one result: found
// with the start offset, or not found on its last byte. No clearing pass after reset.
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wbps_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output wbps_pkg::t_out_item  o_out_item,
    input  wire                  i_cfg_we,
    input  wire  [7:0]           i_cfg_wdata
);

    logic [7:0]     r_len;
    logic           cmd_valid;
    wbps_pkg::t_cmd cmd;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 8'd1;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    wbps_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_pop      (pop)
    );

    wbps_back #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_pop      (pop),
        .i_len      (r_len),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

[verif/tb_wildcard_byte_pattern_scanner.sv]
// testbench of the wildcard byte pattern scanner with its own predictor and result checker
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 6;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    wbps_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    wbps_pkg::t_out_item o_out_item;
    logic                i_cfg_we = 1'b0;
    logic [7:0]          i_cfg_wdata = 8'd0;

    int send_idle_pct = 23;
    int recv_idle_pct = 52;
    int items_sent = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // stimulus side view of the pattern and length
    bit [7:0] pattern_image [wbps_pkg::STORE_SPAN];
    bit [7:0] len_image = 8'd1;
    bit       region_closed = 1'b1;

    // predictor state
    bit [7:0]                      model_store [wbps_pkg::STORE_SPAN];
    bit [wbps_pkg::STORE_SPAN-1:0] model_flags;
    bit [31:0]                     model_count;
    bit                            model_reported;
    bit [7:0]                      model_len;
    wbps_pkg::t_out_item           pending_results [$];
    wbps_pkg::t_out_item           want_result;

    wildcard_byte_pattern_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit byte_hit(int pos, bit [7:0] b);
        return model_store[pos] == wbps_pkg::WILDCARD_BYTE || model_store[pos] == b;
    endfunction

    function automatic void clear_region_state();
        model_flags = '0;
        model_count = 32'd0;
        model_reported = 1'b0;
    endfunction

    function automatic void advance_scanner(wbps_pkg::t_in_item it);
        bit [wbps_pkg::STORE_SPAN-1:0] nxt;
        wbps_pkg::t_out_item res;
        int span;
        if (it.func == wbps_pkg::OP_WRITE) begin
            model_store[it.pattern_index] = it.data_byte;
            return;
        end
        if (it.first_byte)
            clear_region_state();
        span = model_len;
        if (span > wbps_pkg::STORE_SPAN)
            span = wbps_pkg::STORE_SPAN;
        for (int j = wbps_pkg::STORE_SPAN - 1; j > 0; j--)
            nxt[j] = (j < span) && model_flags[j-1] && byte_hit(j, it.data_byte);
        nxt[0] = (span > 0) && byte_hit(0, it.data_byte);
        model_flags = nxt;
        if (!model_reported && span > 0 && model_flags[span-1]) begin
            res.found = 1'b1;
            res.match_offset = model_count - 32'(span - 1);
            pending_results.push_back(res);
            model_reported = 1'b1;
        end
        model_count = model_count + 32'd1;
        if (it.last_byte) begin
            if (!model_reported) begin
                res.found = 1'b0;
                res.match_offset = 32'd0;
                pending_results.push_back(res);
            end
            clear_region_state();
        end
    endfunction

    // result checker and predictor, both on the sampled values of one edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_region_state();
            model_len = 8'd1;
            pending_results.delete();
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with none expected", o_out_item.match_offset,
                                    32'd0);
                end else begin
                    want_result = pending_results.pop_front();
                    if (o_out_item.found !== want_result.found)
                        report_mismatch("found", {31'd0, o_out_item.found},
                                        {31'd0, want_result.found});
                    if (o_out_item.match_offset !== want_result.match_offset)
                        report_mismatch("match_offset", o_out_item.match_offset,
                                        want_result.match_offset);
                end
            end
            if (i_cfg_we) begin
                quiet_cycles = 0;
                model_len = i_cfg_wdata;
            end
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles = 0;
                advance_scanner(i_in_item);
            end
        end
    end

    task automatic send_item(input wbps_pkg::t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input bit [7:0] value);
        wait_results_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        len_image = value;
    endtask

    task automatic write_pattern_byte(input bit [7:0] idx, input bit [7:0] value);
        wbps_pkg::t_in_item it;
        it.func = wbps_pkg::OP_WRITE;
        it.pattern_index = idx;
        it.data_byte = value;
        it.first_byte = 1'($urandom_range(1));
        it.last_byte = 1'($urandom_range(1));
        pattern_image[idx] = value;
        send_item(it);
    endtask

    task automatic scan_byte(input bit [7:0] value, input bit first, input bit last);
        wbps_pkg::t_in_item it;
        it.func = wbps_pkg::OP_SCAN;
        it.pattern_index = 8'($urandom_range(255));
        it.data_byte = value;
        it.first_byte = first;
        it.last_byte = last;
        send_item(it);
    endtask

    function automatic bit [7:0] draw_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return wbps_pkg::WILDCARD_BYTE;
        else if (r < 55)
            return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic bit [7:0] draw_region_byte(int span);
        int r;
        bit [7:0] b;
        r = $urandom_range(99);
        if (r < 35 && span > 0) begin
            b = pattern_image[$urandom_range(span - 1)];
            return (b == wbps_pkg::WILDCARD_BYTE) ? 8'($urandom_range(255)) : b;
        end else if (r < 60) begin
            return 8'($urandom_range(3));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic void plant_pattern(ref bit [7:0] bytes [$], input int at, input int span);
        for (int k = 0; k < span; k++)
            bytes[at+k] = (pattern_image[k] == wbps_pkg::WILDCARD_BYTE) ? 8'($urandom_range(255))
                                                                        : pattern_image[k];
    endfunction

    task automatic load_pattern(input int span);
        for (int k = 0; k < span; k++)
            write_pattern_byte(8'(k), draw_pattern_byte());
    endtask

    task automatic random_region();
        bit [7:0] region_bytes [$];
        int rlen;
        int span;
        int r;
        bit start_flag;
        bit end_flag;
        r = $urandom_range(99);
        if (r < 18) begin
            r = $urandom_range(99);
            if (r < 5)
                write_length(8'd0);
            else if (r < 10)
                write_length(8'($urandom_range(20, 64)));
            else
                write_length(8'($urandom_range(1, 6)));
            load_pattern(len_image);
        end else if (r < 32) begin
            load_pattern(len_image);
        end
        span = len_image;
        rlen = (span == 0) ? $urandom_range(1, 10) : $urandom_range(1, span + 24);
        for (int i = 0; i < rlen; i++)
            region_bytes.push_back(draw_region_byte(span));
        if (span > 0 && rlen >= span && $urandom_range(99) < 60)
            plant_pattern(region_bytes, $urandom_range(rlen - span), span);
        end_flag = 1'b0;
        for (int i = 0; i < rlen; i++) begin
            if ($urandom_range(99) < 3)
                write_pattern_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
            if (i == 0)
                start_flag = !(region_closed && $urandom_range(99) < 15);
            else
                start_flag = ($urandom_range(99) < 2);
            end_flag = (i == rlen - 1) && ($urandom_range(99) >= 5);
            scan_byte(region_bytes[i], start_flag, end_flag);
        end
        region_closed = end_flag;
    endtask

    task automatic test_directed_cases();
        // reset length of one
        write_pattern_byte(8'd0, 8'h5A);
        scan_byte(8'h00, 1'b1, 1'b0);
        scan_byte(8'h5A, 1'b0, 1'b0);
        scan_byte(8'hFF, 1'b0, 1'b1);
        write_length(8'd3);
        write_pattern_byte(8'd0, 8'h12);
        write_pattern_byte(8'd1, wbps_pkg::WILDCARD_BYTE);
        write_pattern_byte(8'd2, 8'h34);
        // one byte region
        scan_byte(8'h12, 1'b1, 1'b1);
        // match ending on the last byte
        scan_byte(8'h12, 1'b1, 1'b0);
        scan_byte(8'h99, 1'b0, 1'b0);
        scan_byte(8'h34, 1'b0, 1'b1);
        scan_byte(8'hFF, 1'b1, 1'b0);
        scan_byte(8'hFF, 1'b0, 1'b0);
        scan_byte(8'hFF, 1'b0, 1'b1);
        // overlapping partial matches
        scan_byte(8'h12, 1'b1, 1'b0);
        scan_byte(8'h12, 1'b0, 1'b0);
        scan_byte(8'h12, 1'b0, 1'b0);
        scan_byte(8'h34, 1'b0, 1'b1);
        // length change in the middle of a region
        scan_byte(8'h12, 1'b1, 1'b0);
        scan_byte(8'h00, 1'b0, 1'b0);
        write_length(8'd2);
        scan_byte(8'h55, 1'b0, 1'b1);
        // pattern write during a scan
        write_length(8'd3);
        scan_byte(8'h12, 1'b1, 1'b0);
        write_pattern_byte(8'd2, 8'h77);
        scan_byte(8'hAB, 1'b0, 1'b0);
        scan_byte(8'h77, 1'b0, 1'b1);
        // zero length never matches
        write_length(8'd0);
        scan_byte(8'hAB, 1'b1, 1'b1);
        region_closed = 1'b1;
    endtask

    task automatic test_full_store();
        bit [7:0] region_bytes [$];
        for (int k = 0; k < wbps_pkg::STORE_SPAN; k++)
            write_pattern_byte(8'(k), draw_pattern_byte());
        write_length(8'd255);
        for (int i = 0; i < 270; i++)
            region_bytes.push_back(draw_region_byte(255));
        plant_pattern(region_bytes, $urandom_range(15), 255);
        for (int i = 0; i < 270; i++)
            scan_byte(region_bytes[i], i == 0, i == 269);
        region_closed = 1'b1;
        write_length(8'd4);
        load_pattern(4);
    endtask

    task automatic test_random_regions(input int item_target);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < item_target)
            random_region();
    endtask

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_regions(120);
        send_idle_pct = 52;
        recv_idle_pct = 23;
        test_full_store();
        test_random_regions(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_regions(120);
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 32'd0, 32'(pending_results.size()));
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
